// ----- hw/rtl/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace core.
// Used by sfr_front, sfr_queue, sfr_back and the top level; no dependencies of its own.
`default_nettype none
package sfr_pkg;

	localparam int CFG_W   = 64;
	localparam int LEN_W   = 4;
	localparam int QDEPTH  = 4;

	typedef enum logic [1:0] {
		REG_PAT_BYTES = 2'd0,
		REG_PAT_LEN   = 2'd1,
		REG_REP_BYTES = 2'd2,
		REG_REP_LEN   = 2'd3
	} sfr_reg_t;

	// control part of one queued job: bytes to emit, end of string
	typedef struct packed {
		logic [LEN_W-1:0] cnt;
		logic             eos;
	} sfr_jctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sfr_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
// Depends on nothing.
`default_nettype none
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, in_byte, end_of_string, input ready);
	modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface sfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       string_done;
	logic       run_last;

	modport source (output valid, out_byte, byte_present, string_done, run_last, input ready);
	modport sink   (input valid, out_byte, byte_present, string_done, run_last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sfr_front.sv -----
// Front end: config registers, match window and per-item classification into jobs.
// Depends on sfr_pkg and sfr_in_if.
`default_nettype none
module sfr_front
	import sfr_pkg::*;
#(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8,
	parameter int JOB_W           = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sfr_in_if.sink                    in_ch,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 q_full,
	output logic                      push,
	output logic [JOB_W*8-1:0]        job_bytes,
	output sfr_jctl_t                 job_ctl
);

	logic [CFG_W-1:0] pat_q, rep_q;
	logic [LEN_W-1:0] plen_q, rlen_q;
	logic [7:0]       win_q [MAX_PATTERN];
	logic [LEN_W-1:0] fill_q;

	logic [7:0]       w   [MAX_PATTERN];
	logic [7:0]       shf [MAX_PATTERN];
	logic [LEN_W-1:0] plen, rlen, nf, fill_d;
	logic             accept, full, match, do_shift;

	assign accept      = in_ch.valid & in_ch.ready;
	assign in_ch.ready = ~q_full;

	assign plen = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;
	assign rlen = (rlen_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_q;
	assign nf   = fill_q + LEN_W'(1);
	assign full = (nf == plen);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			w[i] = (LEN_W'(i) == fill_q) ? in_ch.in_byte : win_q[i];
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			shf[i] = (i < MAX_PATTERN - 1) ? w[(i + 1) % MAX_PATTERN] : w[i];
		end
		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < plen && w[i] != pat_q[8*i +: 8]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		job_bytes   = '0;
		job_ctl.eos = in_ch.end_of_string;
		job_ctl.cnt = '0;
		fill_d      = fill_q;
		do_shift    = 1'b0;
		if (plen == '0) begin
			job_bytes[7:0] = in_ch.in_byte;
			job_ctl.cnt    = LEN_W'(1);
		end else if (full && match) begin
			for (int i = 0; i < MAX_REPLACEMENT; i++) begin
				job_bytes[8*i +: 8] = rep_q[8*i +: 8];
			end
			job_ctl.cnt = rlen;
			fill_d      = '0;
		end else begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				job_bytes[8*i +: 8] = w[i];
			end
			if (full) begin
				do_shift    = 1'b1;
				job_ctl.cnt = in_ch.end_of_string ? plen : LEN_W'(1);
				fill_d      = in_ch.end_of_string ? '0 : plen - LEN_W'(1);
			end else begin
				job_ctl.cnt = in_ch.end_of_string ? nf : '0;
				fill_d      = in_ch.end_of_string ? '0 : nf;
			end
		end
	end

	assign push = accept & ((job_ctl.cnt != '0) | in_ch.end_of_string);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			rep_q  <= '0;
			plen_q <= '0;
			rlen_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (sfr_reg_t'(cfg_idx))
					REG_PAT_BYTES: pat_q <= cfg_wdata;
					REG_PAT_LEN:   plen_q <= cfg_wdata[LEN_W-1:0];
					REG_REP_BYTES: rep_q <= cfg_wdata;
					REG_REP_LEN:   rlen_q <= cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cfg_we && sfr_reg_t'(cfg_idx) == REG_PAT_LEN) begin
				fill_q <= '0;
			end else if (accept && plen != '0) begin
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && plen != '0) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= do_shift ? shf[i] : w[i];
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sfr_queue.sv -----
// Small job FIFO between the classifier and the emitter.
// Depends on sfr_pkg.
`default_nettype none
module sfr_queue
	import sfr_pkg::*;
#(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          pop,
	output logic [DW-1:0]      rdata,
	output logic               full,
	output logic               empty
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	logic [DW-1:0] mem_q [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + PW'(1);
			if (pop)  rptr_q <= rptr_q + PW'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/sfr_back.sv -----
// Back end: walks the head job one byte per unstalled cycle into the output register.
// Depends on sfr_pkg and sfr_out_if.
`default_nettype none
module sfr_back
	import sfr_pkg::*;
#(
	parameter int JOB_W = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	input  wire logic [JOB_W*8-1:0]   job_bytes,
	input  wire sfr_jctl_t            job_ctl,
	output logic                      pop,
	sfr_out_if.source                 out_ch
);

	localparam int IDXW = (JOB_W > 1) ? $clog2(JOB_W) : 1;

	logic [7:0]      b [JOB_W];
	logic [IDXW-1:0] idx_q;
	logic            vld_q, load, last;
	logic [7:0]      byte_q;
	logic            pres_q, done_q, rl_q;

	for (genvar g = 0; g < JOB_W; g++) begin : g_unp
		assign b[g] = job_bytes[8*g +: 8];
	end

	assign load = ~q_empty & (~vld_q | out_ch.ready);
	assign last = (job_ctl.cnt == '0) | (LEN_W'(idx_q) + LEN_W'(1) == job_ctl.cnt);
	assign pop  = load & last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= last ? '0 : idx_q + IDXW'(1);
			end else if (out_ch.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= (job_ctl.cnt == '0) ? 8'h00 : b[idx_q];
			pres_q <= (job_ctl.cnt != '0);
			done_q <= job_ctl.eos & last;
			rl_q   <= last;
		end
	end

	assign out_ch.valid        = vld_q;
	assign out_ch.out_byte     = byte_q;
	assign out_ch.byte_present = pres_q;
	assign out_ch.string_done  = done_q;
	assign out_ch.run_last     = rl_q;

endmodule
`default_nettype wire

// ----- hw/rtl/stream_find_and_replace_core.sv -----
// Top level of the stream find-and-replace core.
// Depends on sfr_pkg, sfr_if, sfr_front, sfr_queue and sfr_back.
//
// Bytes enter one per cycle on in_ch; the front end updates the match window in
// the cycle an item is accepted and queues a job holding every result byte that
// item causes. The back end emits one result per cycle while the output is not
// stalled, from a four-deep job queue through a registered output, so an item
// causing k results gives k results back to back (one for a plain byte, up to
// eight for a replacement or an end-of-string flush); input stalls only when the
// job queue fills. Items that only enter the window produce no result.
// Configuration writes are taken any cycle but must be done while the core is idle.
`default_nettype none
module stream_find_and_replace_core
	import sfr_pkg::*;
#(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	sfr_in_if.sink                in_ch,
	sfr_out_if.source             out_ch,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int JOB_W = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int DW    = JOB_W * 8 + $bits(sfr_jctl_t);

	logic               push, pop, q_full, q_empty;
	logic [JOB_W*8-1:0] f_bytes, b_bytes;
	sfr_jctl_t          f_ctl, b_ctl;
	logic [DW-1:0]      q_rdata;

	sfr_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT),
		.JOB_W           (JOB_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.job_bytes (f_bytes),
		.job_ctl   (f_ctl)
	);

	sfr_queue #(
		.DW (DW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_bytes, f_ctl}),
		.pop    (pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign b_bytes = q_rdata[DW-1 -: JOB_W*8];
	assign b_ctl   = sfr_jctl_t'(q_rdata[$bits(sfr_jctl_t)-1:0]);

	sfr_back #(
		.JOB_W (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.job_bytes (b_bytes),
		.job_ctl   (b_ctl),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/sfr_checker.sv -----
// Port-level assertions for the stream find-and-replace core, and their bind.
// Depends on stream_find_and_replace_core.
`default_nettype none
module sfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       byte_present,
	input wire logic       string_done,
	input wire logic       run_last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("result changed while stalled");

	// bare end marker carries no byte and closes the string
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_present |-> out_byte == 8'h00 && string_done && run_last)
		else $error("malformed end marker");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_done |-> run_last)
		else $error("string end not on last result of item");

	// results of one item leave back to back
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside a run of results");

endmodule

bind stream_find_and_replace_core sfr_checker u_sfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.byte_present (out_ch.byte_present),
	.string_done  (out_ch.string_done),
	.run_last     (out_ch.run_last)
);
`default_nettype wire

// ----- tb/sfr_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the stream find-and-replace core: watches the byte, result
// and register write traffic, predicts each result and compares it field by field.
// Depends on sfr_pkg and sfr_if.
module sfr_result_checker
	import sfr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	sfr_in_if                     in_ch,
	sfr_out_if                    out_ch,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	output int                    pending,
	output int                    fail_count,
	output int                    items_seen,
	output int                    results_seen,
	output int                    hit_count,
	output int                    marker_count
);

	localparam int PAT_MAX = 8;
	localparam int REP_MAX = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       done;
		logic       last;
	} sfr_result_t;

	sfr_result_t      expected_out[$];
	sfr_result_t      got;
	sfr_result_t      want;
	logic [CFG_W-1:0] pat_bytes;
	logic [CFG_W-1:0] rep_bytes;
	logic [LEN_W-1:0] pat_len;
	logic [LEN_W-1:0] rep_len;
	logic [7:0]       window [0:PAT_MAX-1];
	int unsigned      fill;

	function automatic void predict_replace(input logic [7:0] b, input logic eos);
		sfr_result_t res [0:7];
		int          n;
		int          plen;
		int          rlen;
		bit          hit;
		n    = 0;
		plen = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
		rlen = (rep_len > REP_MAX) ? REP_MAX : int'(rep_len);
		if (plen == 0) begin
			res[n] = '{b, 1'b1, 1'b0, 1'b0};
			n++;
		end else begin
			window[fill] = b;
			fill++;
			if (fill == plen) begin
				hit = 1'b1;
				for (int i = 0; i < plen; i++)
					if (window[i] != pat_bytes[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					hit_count++;
					for (int i = 0; i < rlen; i++) begin
						res[n] = '{rep_bytes[8*i +: 8], 1'b1, 1'b0, 1'b0};
						n++;
					end
					fill = 0;
				end else begin
					res[n] = '{window[0], 1'b1, 1'b0, 1'b0};
					n++;
					for (int i = 0; i < PAT_MAX - 1; i++)
						window[i] = window[i+1];
					fill--;
				end
			end
			if (eos) begin
				for (int i = 0; i < fill; i++) begin
					res[n] = '{window[i], 1'b1, 1'b0, 1'b0};
					n++;
				end
				fill = 0;
			end
		end
		// replacement deleted the last bytes of the string: bare end marker
		if (eos && n == 0) begin
			res[n] = '{8'h00, 1'b0, 1'b0, 1'b0};
			n++;
			marker_count++;
		end
		if (n > 0) begin
			res[n-1].done = eos;
			res[n-1].last = 1'b1;
		end
		for (int i = 0; i < n; i++)
			expected_out.push_back(res[i]);
	endfunction

	function automatic void log_mismatch(input string what, input sfr_result_t exp_r,
			input sfr_result_t act_r);
		fail_count++;
		if (fail_count <= 10)
			$display({"%0t: %s: expected byte %02h present %0b done %0b last %0b,",
				" got byte %02h present %0b done %0b last %0b"},
				$time, what, exp_r.data, exp_r.present, exp_r.done, exp_r.last,
				act_r.data, act_r.present, act_r.done, act_r.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_out.delete();
			pat_bytes    = '0;
			rep_bytes    = '0;
			pat_len      = '0;
			rep_len      = '0;
			fill         = 0;
			fail_count   = 0;
			items_seen   = 0;
			results_seen = 0;
			hit_count    = 0;
			marker_count = 0;
			for (int i = 0; i < PAT_MAX; i++)
				window[i] = 8'h00;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (sfr_reg_t'(cfg_idx))
					REG_PAT_BYTES: pat_bytes = cfg_wdata;
					REG_PAT_LEN: begin
						pat_len = cfg_wdata[LEN_W-1:0];
						fill    = 0;
					end
					REG_REP_BYTES: rep_bytes = cfg_wdata;
					REG_REP_LEN: rep_len = cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				items_seen++;
				predict_replace(in_ch.in_byte, in_ch.end_of_string);
			end
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				got = '{out_ch.out_byte, out_ch.byte_present, out_ch.string_done,
					out_ch.run_last};
				if (expected_out.size() == 0) begin
					log_mismatch("unexpected result", '0, got);
				end else begin
					want = expected_out.pop_front();
					if (got !== want)
						log_mismatch("result mismatch", want, got);
				end
			end
			pending <= expected_out.size();
		end
	end

endmodule

// ----- tb/tb_stream_find_and_replace_core.sv -----
`timescale 1ns / 100ps
// Testbench top for stream_find_and_replace_core: clock, reset, byte stimulus,
// register writes and result-side backpressure. Depends on sfr_pkg, sfr_if,
// stream_find_and_replace_core and sfr_result_checker.
module tb_stream_find_and_replace_core;
	import sfr_pkg::*;

	localparam int LIMIT_NS    = 2_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 34;
	localparam int NUM_PHASES  = 9;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             snd_valid = 1'b0;
	logic [7:0]       snd_byte  = 8'h00;
	logic             snd_eos   = 1'b0;
	logic             rcv_ready = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_idx   = 2'd0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             idle_on   = 1'b1;
	logic             long_hold = 1'b0;
	int               hold_cnt  = 0;

	logic [CFG_W-1:0] tb_pat   = '0;
	int               tb_plen  = 0;
	int               settings = 0;

	int pending;
	int fail_count;
	int items_seen;
	int results_seen;
	int hit_count;
	int marker_count;

	sfr_in_if  in_ch();
	sfr_out_if out_ch();

	assign in_ch.valid         = snd_valid;
	assign in_ch.in_byte       = snd_byte;
	assign in_ch.end_of_string = snd_eos;
	assign out_ch.ready        = rcv_ready;

	stream_find_and_replace_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	sfr_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.pending      (pending),
		.fail_count   (fail_count),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.hit_count    (hit_count),
		.marker_count (marker_count)
	);

	always #4 clk = ~clk;

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			hold_cnt  <= 0;
		end else if (long_hold && hold_cnt < HOLD_CYCLES) begin
			rcv_ready <= 1'b0;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			if (!long_hold)
				hold_cnt <= 0;
			rcv_ready <= !(idle_on && $urandom_range(99) < 12);
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("stream_find_and_replace_core test failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		while (idle_on && $urandom_range(99) < 12) begin
			snd_valid <= 1'b0;
			@(posedge clk);
		end
		snd_valid <= 1'b1;
		snd_byte  <= b;
		snd_eos   <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eos_last && i == s.len() - 1);
	endtask

	// stop sending and let all expected results drain
	task automatic settle();
		snd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input sfr_reg_t idx, input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		case (idx)
			REG_PAT_BYTES: tb_pat = v;
			REG_PAT_LEN: tb_plen = (v[LEN_W-1:0] > 8) ? 8 : int'(v[LEN_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_release();
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic set_all(input logic [CFG_W-1:0] pb, input logic [CFG_W-1:0] pl,
			input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] rl);
		cfg_write(REG_PAT_BYTES, pb);
		cfg_write(REG_PAT_LEN, pl);
		cfg_write(REG_REP_BYTES, rb);
		cfg_write(REG_REP_LEN, rl);
		cfg_release();
	endtask

	task automatic random_phase(input int idx);
		int               plen;
		int               rlen;
		int               sent;
		int               k;
		int               j;
		bit               narrow;
		logic [7:0]       b;
		logic [CFG_W-1:0] pb;
		narrow = idx[0] || idx == 4;
		case (idx)
			0: begin plen = 8; rlen = 8; end
			1: begin plen = 1; rlen = 0; end
			2: begin plen = 0; rlen = $urandom_range(0, 8); end
			3: begin plen = 15; rlen = 15; end
			4: begin plen = 2; rlen = 8; end
			default: begin plen = $urandom_range(1, 8); rlen = $urandom_range(0, 8); end
		endcase
		for (int i = 0; i < 8; i++)
			pb[8*i +: 8] = narrow ? ($urandom_range(1) ? 8'h41 : 8'h42) : 8'($urandom_range(255));
		idle_on <= (idx > 1);
		settle();
		set_all(pb, CFG_W'(plen), {$urandom, $urandom}, CFG_W'(rlen));
		if (idx == 4)
			long_hold <= 1'b1;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			if (tb_plen > 0 && $urandom_range(99) < 45) begin
				// whole pattern most of the time, a cut-off prefix otherwise
				k = ($urandom_range(3) == 0) ? $urandom_range(1, tb_plen) : tb_plen;
				for (int i = 0; i < k; i++) begin
					send_byte(tb_pat[8*i +: 8], $urandom_range(9) == 0);
					sent++;
				end
			end else begin
				j = $urandom_range(7);
				if ($urandom_range(1))
					b = tb_pat[8*j +: 8];
				else if (narrow)
					b = $urandom_range(1) ? 8'h41 : 8'h42;
				else
					b = 8'($urandom_range(255));
				send_byte(b, $urandom_range(9) == 0);
				sent++;
			end
		end
		long_hold <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through straight out of reset
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		settle();
		set_all(64'h6261, 2, 64'h5A5958, 3);
		send_text("xaby", 1'b1);

		// oversized lengths with junk above the register width, full-size match at end
		settle();
		set_all('1, '1, '0, '1);
		for (int i = 0; i < 8; i++)
			send_byte(8'hFF, i == 7);

		// empty replacement on the final match
		settle();
		set_all(64'h6261, 2, 64'h0, 0);
		send_text("ab", 1'b1);

		// pending bytes survive a pattern byte rewrite
		settle();
		set_all(64'h636261, 3, 64'h51, 1);
		send_text("ab", 1'b0);
		settle();
		cfg_write(REG_PAT_BYTES, 64'h646261);
		cfg_release();
		send_text("d", 1'b1);

		// pending bytes dropped by a pattern length rewrite
		send_text("a", 1'b0);
		settle();
		cfg_write(REG_PAT_LEN, 3);
		cfg_release();
		send_text("bc", 1'b1);

		for (int p = 0; p < NUM_PHASES; p++)
			random_phase(p);

		settle();
		repeat (20) @(posedge clk);
		$display("Sent %0d items under %0d register settings; checked %0d results,",
			items_seen, settings, results_seen);
		$display("including %0d pattern hits and %0d bare end markers.",
			hit_count, marker_count);
		if (fail_count == 0 && pending == 0) begin
			$display("stream_find_and_replace_core test passed");
		end else begin
			$display("stream_find_and_replace_core test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_if.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_and_replace_core.sv
hw/rtl/sfr_checker.sv
tb/sfr_result_checker.sv
tb/tb_stream_find_and_replace_core.sv
